@@ hw/rtl/hcr_pkg.sv @@
// Shared constants and types for the Harris corner response block.
// No dependencies; imported by every module of the block.
package hcr_pkg;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_PIXEL_BITS = 8;
  localparam int MAX_HEIGHT     = 4096;

  localparam int ROW_BITS  = 12;
  localparam int COL_BITS  = 10;
  localparam int R_BITS    = 48;
  localparam int K_BITS    = 16;
  localparam int CFG_BITS  = 48;
  localparam int IDX_BITS  = 8;
  localparam int OUT_BITS  = 72;

  localparam logic [IDX_BITS-1:0] REG_WIDTH     = 8'd0;
  localparam logic [IDX_BITS-1:0] REG_HEIGHT    = 8'd1;
  localparam logic [IDX_BITS-1:0] REG_K         = 8'd2;
  localparam logic [IDX_BITS-1:0] REG_THRESHOLD = 8'd3;

  localparam logic [10:0] RST_WIDTH  = 11'd640;
  localparam logic [12:0] RST_HEIGHT = 13'd480;
  localparam logic [15:0] RST_K      = 16'd2621;

  // Output word layout, highest bit first.
  typedef struct packed {
    logic                     is_corner;
    logic signed [R_BITS-1:0] r_value;
    logic                     in_region;
    logic [COL_BITS-1:0]      center_col;
    logic [ROW_BITS-1:0]      center_row;
  } result_t;

endpackage

@@ hw/rtl/hcr_line_mem.sv @@
// Line store: four previous rows of pixels, one column per entry.
// Synchronous memory with one write port and one registered read port; uses hcr_pkg.
module hcr_line_mem #(
  parameter int MAX_WIDTH  = hcr_pkg::DEF_MAX_WIDTH,
  parameter int PIXEL_BITS = hcr_pkg::DEF_PIXEL_BITS
) (
  input  logic                             clk,
  input  logic                             rd_en,
  input  logic [$clog2(MAX_WIDTH)-1:0]     rd_addr,
  output logic [4*PIXEL_BITS-1:0]          rd_data,
  input  logic                             wr_en,
  input  logic [$clog2(MAX_WIDTH)-1:0]     wr_addr,
  input  logic [4*PIXEL_BITS-1:0]          wr_data
);
  import hcr_pkg::*;

  logic [4*PIXEL_BITS-1:0] mem [MAX_WIDTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ hw/rtl/hcr_resp.sv @@
// Response unit: gradients over the 5x5 window, 3x3 structure sums and R.
// Iterates one gradient pair per cycle on one multiplier set; uses hcr_pkg.
module hcr_resp #(
  parameter int PIXEL_BITS = hcr_pkg::DEF_PIXEL_BITS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic [PIXEL_BITS-1:0]              win [5][5],
  input  logic [hcr_pkg::K_BITS-1:0]         harris_k,
  output logic                               done,
  output logic signed [hcr_pkg::R_BITS-1:0]  r_value
);
  import hcr_pkg::*;

  localparam int GW = PIXEL_BITS + 3;
  localparam int SW = 2 * GW + 4;
  localparam int TW = SW + 1;
  localparam int QW = 2 * TW;
  localparam int HW = QW - 32;
  localparam int RW = QW + 3;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_GRAD = 7'b0000010,
    S_ACC  = 7'b0000100,
    S_DET  = 7'b0001000,
    S_SQ   = 7'b0010000,
    S_KT   = 7'b0100000,
    S_R    = 7'b1000000
  } state_t;

  state_t state;
  logic [3:0] step;

  logic signed [GW-1:0] gx_c [9];
  logic signed [GW-1:0] gy_c [9];
  logic signed [GW-1:0] gx [9];
  logic signed [GW-1:0] gy [9];
  logic signed [SW-1:0] sxx, syy, sxy;
  logic signed [2*SW-1:0] pxx_yy, pxy_xy;
  logic [TW-1:0] t;
  logic [QW-1:0] t2;
  logic [HW+K_BITS-1:0] hk;
  logic [32+K_BITS-1:0] lk;
  logic signed [RW-1:0] det, kt, r_full;
  logic signed [2*GW-1:0] mxx, myy, mxy;

  always_comb begin
    for (int y = 1; y <= 3; y++) begin
      for (int x = 1; x <= 3; x++) begin
        gx_c[(y-1)*3 + (x-1)] =
          GW'($signed({1'b0, win[y-1][x+1]})) - GW'($signed({1'b0, win[y-1][x-1]})) +
          GW'($signed({1'b0, win[y][x+1]}))   - GW'($signed({1'b0, win[y][x-1]})) +
          GW'($signed({1'b0, win[y+1][x+1]})) - GW'($signed({1'b0, win[y+1][x-1]}));
        gy_c[(y-1)*3 + (x-1)] =
          GW'($signed({1'b0, win[y+1][x-1]})) - GW'($signed({1'b0, win[y-1][x-1]})) +
          GW'($signed({1'b0, win[y+1][x]}))   - GW'($signed({1'b0, win[y-1][x]})) +
          GW'($signed({1'b0, win[y+1][x+1]})) - GW'($signed({1'b0, win[y-1][x+1]}));
      end
    end
  end

  assign mxx = gx[0] * gx[0];
  assign myy = gy[0] * gy[0];
  assign mxy = gx[0] * gy[0];

  // The split products are ready in S_R, so k*trace^2 is summed there directly.
  assign kt     = RW'({hk, 16'b0}) + RW'(lk[32+K_BITS-1:16]);
  assign r_full = det - kt;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            state <= S_GRAD;
          end
        end
        S_GRAD: begin
          step  <= '0;
          state <= S_ACC;
        end
        S_ACC: begin
          step <= step + 4'd1;
          if (step == 4'd8) begin
            state <= S_DET;
          end
        end
        S_DET: state <= S_SQ;
        S_SQ:  state <= S_KT;
        S_KT:  state <= S_R;
        S_R: begin
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_GRAD: begin
        gx  <= gx_c;
        gy  <= gy_c;
        sxx <= '0;
        syy <= '0;
        sxy <= '0;
      end
      S_ACC: begin
        sxx <= sxx + SW'(mxx);
        syy <= syy + SW'(myy);
        sxy <= sxy + SW'(mxy);
        for (int i = 0; i < 8; i++) begin
          gx[i] <= gx[i+1];
          gy[i] <= gy[i+1];
        end
      end
      S_DET: begin
        pxx_yy <= sxx * syy;
        pxy_xy <= sxy * sxy;
        t      <= TW'(sxx) + TW'(syy);
      end
      S_SQ: begin
        det <= RW'(pxx_yy) - RW'(pxy_xy);
        t2  <= QW'(t) * QW'(t);
      end
      S_KT: begin
        hk <= t2[QW-1:32] * harris_k;
        lk <= t2[31:0] * harris_k;
      end
      S_R: begin
        if (r_full > RW'(signed'({1'b0, {(R_BITS-1){1'b1}}}))) begin
          r_value <= {1'b0, {(R_BITS-1){1'b1}}};
        end else if (r_full < -(RW'(1) <<< (R_BITS-1))) begin
          r_value <= {1'b1, {(R_BITS-1){1'b0}}};
        end else begin
          r_value <= r_full[R_BITS-1:0];
        end
      end
      default: begin
      end
    endcase
  end

endmodule

@@ hw/rtl/harris_corner_response.sv @@
// Harris corner response top level: stream ports, counters, window and control.
// Uses hcr_pkg, hcr_line_mem and hcr_resp.
//
// Usage: pixels arrive in raster order on the s_ group, one word each; tdata holds
// the pixel, tuser holds frame_start, which restarts the row and column counters.
// Each pixel yields one result word on the m_ group for the pixel two rows and two
// columns back; tlast marks the result caused by the frame's final pixel.
// Registers are written on the cfg_ channel (0 width, 1 height, 2 k, 3 threshold)
// while no pixel is in flight; cfg_ready is always high.
// A pixel in the region waits for the response unit, which walks the nine gradient
// pairs on one multiplier set, then four arithmetic steps; a pixel outside it skips
// the unit. One pixel is in work at a time; s_tready is high when the previous pixel
// has been handed to the output register. If the receiver stalls, the finished word
// waits in the output register and the next pixel may be accepted meanwhile.
// Reset clears the counters, the window and the registers to their defaults; the
// line store is not cleared, and its rows are valid once written by the frame.
module harris_corner_response #(
  parameter int MAX_WIDTH  = hcr_pkg::DEF_MAX_WIDTH,
  parameter int PIXEL_BITS = hcr_pkg::DEF_PIXEL_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [((PIXEL_BITS+7)/8)*8-1:0]     s_tdata,   // pixel
  input  logic                                s_tuser,   // frame_start
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [hcr_pkg::OUT_BITS-1:0]        m_tdata,   // center_row, center_col,
                                                         // in_region, r_value, is_corner
  output logic                                m_tlast,   // last
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [hcr_pkg::IDX_BITS-1:0]        cfg_index,
  input  logic [hcr_pkg::CFG_BITS-1:0]        cfg_data
);
  import hcr_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int SB = 16;

  typedef enum logic [3:0] {
    T_IDLE = 4'b0001,
    T_WIN  = 4'b0010,
    T_RESP = 4'b0100,
    T_OUT  = 4'b1000
  } tstate_t;

  tstate_t state;

  logic [10:0] image_width;
  logic [12:0] image_height;
  logic [K_BITS-1:0] harris_k;
  logic signed [R_BITS-1:0] corner_threshold;

  logic [CW-1:0] col_count;
  logic [ROW_BITS-1:0] row_count;
  logic [CW-1:0] col_c;
  logic [ROW_BITS-1:0] row_c;
  logic [SB-1:0] w, h;
  logic signed [SB-1:0] crow_c, ccol_c;
  logic region_c, last_c, col_end;

  logic [PIXEL_BITS-1:0] pix;
  logic [CW-1:0] cur_col;
  logic [PIXEL_BITS-1:0] win [5][5];
  logic [4*PIXEL_BITS-1:0] rd_data;
  logic [PIXEL_BITS-1:0] column [5];

  logic resp_start, resp_done;
  logic resp_busy;
  logic signed [R_BITS-1:0] resp_r;
  result_t res;
  logic res_last;
  logic accept;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == T_IDLE);
  assign accept    = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width      <= RST_WIDTH;
      image_height     <= RST_HEIGHT;
      harris_k         <= RST_K;
      corner_threshold <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_WIDTH:     image_width      <= cfg_data[10:0];
        REG_HEIGHT:    image_height     <= cfg_data[12:0];
        REG_K:         harris_k         <= cfg_data[K_BITS-1:0];
        REG_THRESHOLD: corner_threshold <= cfg_data[R_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  // Clamped frame size.
  always_comb begin
    if (image_width < 11'd5) begin
      w = SB'(5);
    end else if (SB'(image_width) > SB'(MAX_WIDTH)) begin
      w = SB'(MAX_WIDTH);
    end else begin
      w = SB'(image_width);
    end
    if (image_height < 13'd5) begin
      h = SB'(5);
    end else if (SB'(image_height) > SB'(MAX_HEIGHT)) begin
      h = SB'(MAX_HEIGHT);
    end else begin
      h = SB'(image_height);
    end
  end

  always_comb begin
    col_c = s_tuser ? '0 : col_count;
    row_c = s_tuser ? '0 : row_count;
    if (col_c >= CW'(2)) begin
      crow_c = signed'(SB'(row_c)) - SB'(2);
      ccol_c = signed'(SB'(col_c)) - SB'(2);
    end else begin
      crow_c = signed'(SB'(row_c)) - SB'(3);
      ccol_c = signed'(SB'(col_c)) + signed'(w) - SB'(2);
    end
    region_c = (crow_c >= SB'(2)) && (crow_c <= signed'(h) - SB'(3)) &&
               (ccol_c >= SB'(2)) && (ccol_c <= signed'(w) - SB'(3));
    col_end = SB'(col_c) >= w - SB'(1);
    last_c  = col_end && (SB'(row_c) >= h - SB'(1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else if (accept) begin
      if (col_end) begin
        col_count <= '0;
        row_count <= last_c ? '0 : row_c + ROW_BITS'(1);
      end else begin
        col_count <= col_c + CW'(1);
        row_count <= row_c;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pix                <= s_tdata[PIXEL_BITS-1:0];
      cur_col            <= col_c;
      res.center_row     <= crow_c[ROW_BITS-1:0];
      res.center_col     <= ccol_c[COL_BITS-1:0];
      res.in_region      <= region_c;
      res_last           <= last_c;
    end
    if (state == T_RESP && resp_done) begin
      res.r_value   <= resp_r;
      res.is_corner <= resp_r > corner_threshold;
    end else if (state == T_WIN) begin
      res.r_value   <= '0;
      res.is_corner <= 1'b0;
    end
  end

  hcr_line_mem #(
    .MAX_WIDTH  (MAX_WIDTH),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_lines (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (col_c),
    .rd_data (rd_data),
    .wr_en   (state == T_WIN),
    .wr_addr (cur_col),
    .wr_data ({column[4], column[3], column[2], column[1]})
  );

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      column[k] = rd_data[k*PIXEL_BITS +: PIXEL_BITS];
    end
    column[4] = pix;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int y = 0; y < 5; y++) begin
        for (int x = 0; x < 5; x++) begin
          win[y][x] <= '0;
        end
      end
    end else if (state == T_WIN) begin
      for (int y = 0; y < 5; y++) begin
        for (int x = 0; x < 4; x++) begin
          win[y][x] <= win[y][x+1];
        end
        win[y][4] <= column[y];
      end
    end
  end

  assign resp_start = (state == T_RESP) && !resp_busy;

  // The unit starts in the cycle after the window shifts, so it sees the new window.
  always_ff @(posedge clk) begin
    if (rst) begin
      resp_busy <= 1'b0;
    end else if (resp_start) begin
      resp_busy <= 1'b1;
    end else if (resp_done) begin
      resp_busy <= 1'b0;
    end
  end

  hcr_resp #(
    .PIXEL_BITS (PIXEL_BITS)
  ) u_resp (
    .clk      (clk),
    .rst      (rst),
    .start    (resp_start),
    .win      (win),
    .harris_k (harris_k),
    .done     (resp_done),
    .r_value  (resp_r)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= T_IDLE;
    end else begin
      unique case (state)
        T_IDLE: if (accept) state <= T_WIN;
        T_WIN:  state <= res.in_region ? T_RESP : T_OUT;
        T_RESP: if (resp_done) state <= T_OUT;
        T_OUT:  if (!m_tvalid || m_tready) state <= T_IDLE;
        default: state <= T_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == T_OUT && (!m_tvalid || m_tready)) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == T_OUT && (!m_tvalid || m_tready)) begin
      m_tdata <= res;
      m_tlast <= res_last;
    end
  end

endmodule

@@ test/tb_harris_corner_response.sv @@
// Testbench for harris_corner_response: drives pixel frames, predicts every result word.
// Depends on hcr_pkg and the harris_corner_response RTL only.
`timescale 1ns / 1ps

module tb_harris_corner_response;
  import hcr_pkg::*;

  localparam int MAX_WIDTH_TB = 1024;

  logic                 clk;
  logic                 rst;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [7:0]           s_tdata;
  logic                 s_tuser;
  logic                 m_tvalid;
  logic                 m_tready;
  logic [OUT_BITS-1:0]  m_tdata;
  logic                 m_tlast;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [IDX_BITS-1:0]  cfg_index;
  logic [CFG_BITS-1:0]  cfg_data;

  harris_corner_response u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  typedef struct {
    result_t word;
    bit      last;
  } response_word_t;

  // Predictor state.
  bit [10:0]        img_w;
  bit [12:0]        img_h;
  bit [15:0]        k_q16;
  bit signed [47:0] thr;
  bit [7:0]         lines [4][MAX_WIDTH_TB];
  bit [7:0]         win [5][5];
  int unsigned      row_cnt;
  int unsigned      col_cnt;

  response_word_t   expected_words[$];
  int               errors;
  bit               quiet;
  bit               hold_req;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic longint grad_x(int y, int x);
    longint s;
    s = 0;
    for (int d = -1; d <= 1; d++) s += longint'(win[y+d][x+1]) - longint'(win[y+d][x-1]);
    return s;
  endfunction

  function automatic longint grad_y(int y, int x);
    longint s;
    s = 0;
    for (int d = -1; d <= 1; d++) s += longint'(win[y+1][x+d]) - longint'(win[y-1][x+d]);
    return s;
  endfunction

  function automatic longint harris_response();
    longint          sxx, syy, sxy, gx, gy, det, r;
    longint unsigned t, t2, hi, lo, kt;
    longint          lim;
    sxx = 0; syy = 0; sxy = 0;
    for (int y = 1; y <= 3; y++)
      for (int x = 1; x <= 3; x++) begin
        gx = grad_x(y, x);
        gy = grad_y(y, x);
        sxx += gx * gx;
        syy += gy * gy;
        sxy += gx * gy;
      end
    det = sxx * syy - sxy * sxy;
    t   = longint'(sxx) + longint'(syy);
    t2  = t * t;
    hi  = t2 >> 32;
    lo  = t2 & 64'hFFFF_FFFF;
    kt  = ((hi * k_q16) << 16) + ((lo * k_q16) >> 16);
    r   = det - longint'(kt);
    lim = longint'(1) << 47;
    if (r > lim - 1) r = lim - 1;
    if (r < -lim) r = -lim;
    return r;
  endfunction

  // Advances the predictor by one pixel and returns the word it must produce.
  function automatic response_word_t predict_corner(bit [7:0] pix, bit fs);
    response_word_t  res;
    int unsigned     w, h, col, row;
    bit [7:0]        column [5];
    int              crow, ccol;
    bit              region;
    longint          r;
    w = img_w;
    h = img_h;
    if (w < 5) w = 5;
    if (w > MAX_WIDTH_TB) w = MAX_WIDTH_TB;
    if (h < 5) h = 5;
    if (h > MAX_HEIGHT) h = MAX_HEIGHT;
    if (fs) begin
      row_cnt = 0;
      col_cnt = 0;
    end
    col = col_cnt;
    row = row_cnt;
    if (col >= MAX_WIDTH_TB) col = MAX_WIDTH_TB - 1;
    for (int i = 0; i < 4; i++) column[i] = lines[i][col];
    column[4] = pix;
    for (int i = 0; i < 4; i++) lines[i][col] = column[i+1];
    for (int y = 0; y < 5; y++) begin
      for (int x = 0; x < 4; x++) win[y][x] = win[y][x+1];
      win[y][4] = column[y];
    end
    if (col >= 2) begin
      crow = int'(row) - 2;
      ccol = int'(col) - 2;
    end else begin
      crow = int'(row) - 3;
      ccol = int'(col) + int'(w) - 2;
    end
    region = crow >= 2 && crow <= int'(h) - 3 && ccol >= 2 && ccol <= int'(w) - 3;
    r = region ? harris_response() : 0;
    res.word.center_row = crow[11:0];
    res.word.center_col = ccol[9:0];
    res.word.in_region  = region;
    res.word.r_value    = r[47:0];
    res.word.is_corner  = region && (r > longint'(thr));
    res.last = (col_cnt >= w - 1) && (row_cnt >= h - 1);
    if (col_cnt >= w - 1) begin
      col_cnt = 0;
      if (row_cnt >= h - 1) row_cnt = 0;
      else row_cnt++;
    end else begin
      col_cnt++;
    end
    return res;
  endfunction

  task automatic send_pixel(bit [7:0] pix, bit fs);
    if (!quiet && $urandom_range(99) < 10) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= pix;
    s_tuser  <= fs;
    do @(posedge clk); while (!s_tready);
    expected_words.push_back(predict_corner(pix, fs));
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    wait (expected_words.size() == 0);
    repeat (24) @(posedge clk);
  endtask

  // Writes a set of registers back to back on an idle block.
  task automatic write_regs(bit [IDX_BITS-1:0] idx[$], bit [CFG_BITS-1:0] val[$]);
    wait_drained();
    foreach (idx[i]) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      do @(posedge clk); while (!cfg_ready);
      case (idx[i])
        REG_WIDTH:     img_w = val[i][10:0];
        REG_HEIGHT:    img_h = val[i][12:0];
        REG_K:         k_q16 = val[i][15:0];
        REG_THRESHOLD: thr   = val[i][47:0];
        default: ;
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic set_frame(int w, int h, int k, longint t);
    write_regs('{REG_WIDTH, REG_HEIGHT, REG_K, REG_THRESHOLD},
               '{CFG_BITS'(w), CFG_BITS'(h), CFG_BITS'(k), CFG_BITS'(t)});
  endtask

  function automatic bit [7:0] pattern_pixel(int mode, int r, int c);
    case (mode)
      0: return 8'($urandom);
      1: return (((r / 3) + (c / 3)) & 1) ? 8'hFF : 8'h00;
      2: return 8'hFF;
      3: return 8'h00;
      default: return (r >= 3 && c >= 3) ? 8'($urandom_range(200, 255)) : 8'($urandom_range(0, 40));
    endcase
  endfunction

  // Sends n pixels of a frame of width w, with frame_start on the first one.
  task automatic send_frame(int w, int n, int mode);
    for (int i = 0; i < n; i++) send_pixel(pattern_pixel(mode, i / w, i % w), i == 0);
  endtask

  task automatic test_extremes();
    set_frame(5, 5, 0, -(longint'(1) << 47));
    send_frame(5, 25, 2);
    send_frame(5, 25, 3);
    send_frame(5, 25, 4);
    set_frame(7, 6, 65535, (longint'(1) << 47) - 1);
    send_frame(7, 42, 1);
    send_frame(7, 42, 0);
  endtask

  task automatic test_size_clamp();
    set_frame(3, 2, 2621, 0);
    send_frame(5, 25, 0);
    // Widest row with the shortest frame; the width clamps to the line length.
    set_frame(2047, 0, 1000, 0);
    send_frame(1024, 1100, 0);
    set_frame(6, 8191, 2621, 100);
    send_frame(6, 40, 4);
  endtask

  task automatic test_resize_mid_frame();
    set_frame(8, 8, 2621, 0);
    send_frame(8, 30, 0);
    set_frame(6, 6, 3000, -5000);
    for (int i = 0; i < 50; i++) send_pixel(8'($urandom), 1'b0);
    write_regs('{8'd5, 8'hFF}, '{48'h1234, 48'hFFFF_FFFF_FFFF});
    send_frame(6, 36, 1);
  endtask

  task automatic test_restart_mid_frame();
    set_frame(9, 7, 2621, 0);
    send_frame(9, 40, 0);
    send_frame(9, 63, 4);
  endtask

  task automatic test_output_stall();
    set_frame(10, 8, 2621, 0);
    quiet = 1'b1;
    hold_req = 1'b1;
    send_frame(10, 80, 0);
    quiet = 1'b0;
  endtask

  task automatic test_random_frames();
    int sent, w, h, n;
    longint t;
    sent = 0;
    while (sent < 300) begin
      w = $urandom_range(5, 14);
      h = $urandom_range(5, 10);
      case ($urandom_range(3))
        0: t = 0;
        1: t = -longint'($urandom_range(1000000));
        2: t = longint'($urandom);
        default: t = longint'($urandom) * longint'($urandom_range(1, 4000));
      endcase
      set_frame(w, h, $urandom_range(65535), t);
      quiet = ($urandom_range(5) == 0);
      for (int f = $urandom_range(1, 3); f > 0; f--) begin
        n = ($urandom_range(9) == 0) ? $urandom_range(1, w * h) : w * h;
        send_frame(w, n, ($urandom_range(3) == 0) ? $urandom_range(1, 4) : 0);
        sent += n;
      end
      quiet = 1'b0;
    end
  endtask

  // Receiver side: random stalls, plus one long hold-off on request.
  initial begin
    int stall;
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        m_tready <= 1'b0;
        for (stall = 0; stall < 300; stall++) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        m_tready <= quiet || ($urandom_range(99) >= 10);
      end
    end
  end

  always @(posedge clk) begin
    response_word_t exp_w;
    result_t        got;
    if (!rst && m_tvalid && m_tready) begin
      got = result_t'(m_tdata);
      if (expected_words.size() == 0) begin
        $error("result word with none expected: %h", m_tdata);
        errors++;
      end else begin
        exp_w = expected_words.pop_front();
        if (got.center_row !== exp_w.word.center_row) begin
          $error("center_row expected %0d got %0d", exp_w.word.center_row, got.center_row);
          errors++;
        end
        if (got.center_col !== exp_w.word.center_col) begin
          $error("center_col expected %0d got %0d", exp_w.word.center_col, got.center_col);
          errors++;
        end
        if (got.in_region !== exp_w.word.in_region) begin
          $error("in_region expected %0d got %0d", exp_w.word.in_region, got.in_region);
          errors++;
        end
        if (got.r_value !== exp_w.word.r_value) begin
          $error("r_value expected %0d got %0d", exp_w.word.r_value, got.r_value);
          errors++;
        end
        if (got.is_corner !== exp_w.word.is_corner) begin
          $error("is_corner expected %0d got %0d", exp_w.word.is_corner, got.is_corner);
          errors++;
        end
        if (m_tlast !== exp_w.last) begin
          $error("last expected %0d got %0d", exp_w.last, m_tlast);
          errors++;
        end
      end
    end
  end

  initial begin
    int guard;
    errors = 0;
    quiet = 1'b0;
    hold_req = 1'b0;
    img_w = RST_WIDTH;
    img_h = RST_HEIGHT;
    k_q16 = RST_K;
    thr = '0;
    row_cnt = 0;
    col_cnt = 0;
    foreach (lines[i, j]) lines[i][j] = '0;
    foreach (win[i, j]) win[i][j] = '0;
    rst <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    s_tuser <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_extremes();
    test_size_clamp();
    test_resize_mid_frame();
    test_restart_mid_frame();
    test_output_stall();
    test_random_frames();
    s_tvalid <= 1'b0;
    guard = 0;
    while (expected_words.size() != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    repeat (40) @(posedge clk);
    if (errors == 0 && expected_words.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      if (expected_words.size() != 0) $error("%0d result words missing", expected_words.size());
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
